### src/sparse_column_variance_macros.svh
// Assertion helpers for the column variance block.
`ifndef SPARSE_COLUMN_VARIANCE_MACROS_SVH
`define SPARSE_COLUMN_VARIANCE_MACROS_SVH

`ifndef SYNTHESIS
`define SVC_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
`define SVC_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define SVC_ASSERT_NOW(label, pre, post)
`define SVC_ASSERT_NEXT(label, pre, post)
`endif

`endif

### src/svc_pkg.sv
package svc_pkg;

    localparam int COUNT_W = 21;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam int NUM_W = 64 + COUNT_W + 1;
    localparam int DIV_CNT_W = $clog2(NUM_W);
    localparam logic [COUNT_W-1:0] ROW_COUNT_RESET = COUNT_W'(2);
    localparam logic ADDR_ROW_COUNT = 1'b0;

    typedef struct packed {
        logic signed [31:0] sample_value;
        logic signed [31:0] col_mean;
        logic               has_value;
        logic               end_of_column;
    } sample_req_t;

    typedef struct packed {
        logic [63:0] variance;
        logic        overflow;
    } result_req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_ACC,
        ST_MSQ,
        ST_MLO,
        ST_MHI,
        ST_NUM,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        MUL_DEV,
        MUL_MEAN,
        MUL_LO,
        MUL_HI
    } mul_sel_t;

    typedef struct packed {
        logic     load_in;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     acc_en;
        logic     msq_load;
        logic     plo_load;
        logic     num_load;
        logic     div_step;
        logic     out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic last;
        logic div_last;
        logic out_free;
    } dp_status_t;

endpackage

### src/svc_ctrl.sv
module svc_ctrl
    import svc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       sample_valid,
    output logic       sample_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    state_next = ST_SQ;
                end
            end
            ST_SQ:   state_next = ST_ACC;
            ST_ACC:  state_next = status.last ? ST_MSQ : ST_IDLE;
            ST_MSQ:  state_next = ST_MLO;
            ST_MLO:  state_next = ST_MHI;
            ST_MHI:  state_next = ST_NUM;
            ST_NUM:  state_next = ST_DIV;
            ST_DIV:
            begin
                if (status.div_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.mul_sel = MUL_DEV;
        sample_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                sample_ready = 1'b1;
                cmd.load_in = sample_valid;
            end
            ST_SQ:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_sel = MUL_DEV;
            end
            ST_ACC:  cmd.acc_en = 1'b1;
            ST_MSQ:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_sel = MUL_MEAN;
            end
            ST_MLO:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_sel = MUL_LO;
                cmd.msq_load = 1'b1;
            end
            ST_MHI:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_sel = MUL_HI;
                cmd.plo_load = 1'b1;
            end
            ST_NUM:  cmd.num_load = 1'b1;
            ST_DIV:  cmd.div_step = 1'b1;
            ST_DONE: cmd.out_load = status.out_free;
            default: cmd = '0;
        endcase
    end

endmodule

### src/svc_datapath.sv
module svc_datapath
    import svc_pkg::*;
#(
    parameter int MAX_ROWS = 1048576
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  sample_req_t        sample,
    input  logic [COUNT_W-1:0] row_count,
    input  ctrl_cmd_t          cmd,
    output dp_status_t         status,
    output logic               result_valid,
    input  logic               result_ready,
    output result_req_t        result
);

    localparam logic [COUNT_W-1:0] ROWS_CAP =
        (MAX_ROWS > int'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(MAX_ROWS);

    logic signed [31:0] x_reg;
    logic signed [31:0] m_reg;
    logic               has_reg;
    logic               last_reg;
    logic [63:0]        prod_reg;
    logic [63:0]        msq_reg;
    logic [52:0]        plo_reg;
    logic [63:0]        sum_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               sat_reg;
    logic [NUM_W-1:0]   num_reg;
    logic [COUNT_W-1:0] rem_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic               out_valid_reg;
    result_req_t        out_reg;

    logic signed [32:0] diff;
    logic [32:0]        diff_abs;
    logic [31:0]        mean_abs;
    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic [63:0]        prod_next;
    logic [64:0]        sum_wide;
    logic [COUNT_W-1:0] rows;
    logic [COUNT_W-1:0] zeros;
    logic [COUNT_W-1:0] divisor;
    logic [NUM_W-1:0]   num_next;
    logic [COUNT_W:0]   trial;
    logic               trial_ge;
    logic [COUNT_W:0]   trial_sub;
    logic               q_ovf;

    assign diff     = {x_reg[31], x_reg} - {m_reg[31], m_reg};
    assign diff_abs = diff[32] ? 33'(-diff) : diff;
    assign mean_abs = m_reg[31] ? 32'(-m_reg) : m_reg;

    assign rows    = (row_count > ROWS_CAP) ? ROWS_CAP : row_count;
    assign zeros   = (count_reg < rows) ? rows - count_reg : '0;
    assign divisor = (rows >= COUNT_W'(2)) ? rows - COUNT_W'(1) : COUNT_W'(1);

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_DEV:
            begin
                mul_a = diff_abs[31:0];
                mul_b = diff_abs[31:0];
            end
            MUL_MEAN:
            begin
                mul_a = mean_abs;
                mul_b = mean_abs;
            end
            MUL_LO:
            begin
                mul_a = prod_reg[31:0];
                mul_b = 32'(zeros);
            end
            default:
            begin
                mul_a = msq_reg[63:32];
                mul_b = 32'(zeros);
            end
        endcase
    end

    assign prod_next = 64'(mul_a) * 64'(mul_b);
    assign sum_wide  = {1'b0, sum_reg} + {1'b0, prod_reg};
    assign num_next  = NUM_W'({prod_reg[52:0], 32'b0}) + NUM_W'(plo_reg) + NUM_W'(sum_reg);

    assign trial     = {rem_reg, num_reg[NUM_W-1]};
    assign trial_ge  = trial >= {1'b0, divisor};
    assign trial_sub = trial - {1'b0, divisor};
    assign q_ovf     = sat_reg || (|num_reg[NUM_W-1:64]);

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            x_reg    <= sample.sample_value;
            m_reg    <= sample.col_mean;
            has_reg  <= sample.has_value;
            last_reg <= sample.end_of_column;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.msq_load)
        begin
            msq_reg <= prod_reg;
        end
        if (cmd.plo_load)
        begin
            plo_reg <= prod_reg[52:0];
        end
        if (cmd.num_load)
        begin
            num_reg <= num_next;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            num_reg <= {num_reg[NUM_W-2:0], trial_ge};
            rem_reg <= trial_ge ? trial_sub[COUNT_W-1:0] : trial[COUNT_W-1:0];
        end
        if (cmd.out_load)
        begin
            out_reg.variance <= q_ovf ? '1 : num_reg[63:0];
            out_reg.overflow <= q_ovf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            count_reg     <= '0;
            sat_reg       <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.out_load)
            begin
                sum_reg   <= '0;
                count_reg <= '0;
                sat_reg   <= 1'b0;
            end
            else if (cmd.acc_en && has_reg)
            begin
                if (sum_wide[64])
                begin
                    sum_reg <= '1;
                    sat_reg <= 1'b1;
                end
                else
                begin
                    sum_reg <= sum_wide[63:0];
                end
                if (count_reg != COUNT_MAX)
                begin
                    count_reg <= count_reg + COUNT_W'(1);
                end
            end
            if (cmd.num_load)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                cnt_reg <= cnt_reg + DIV_CNT_W'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.last     = last_reg;
    assign status.div_last = cnt_reg == DIV_CNT_W'(NUM_W - 1);
    assign status.out_free = !out_valid_reg || result_ready;

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

### src/sparse_column_variance.sv
// Sample variance of one sparse column. Requests on the sample channel carry one
// stored nonzero (or an empty-column marker) with the column mean; a request with
// end_of_column set yields one result, variance in unsigned Q32.32 with an overflow
// flag. Requests are taken one at a time: each nonzero is accepted, squared
// on the shared 32x32 multiplier and accumulated. A column end then forms the
// mean-squared times implicit-zero product on the same multiplier, runs the
// bit-serial divider and loads the result register.
// The result register lets the next request start while a result waits.
// row_count is written through the APB port at address 0.
`include "sparse_column_variance_macros.svh"

module sparse_column_variance
    import svc_pkg::*;
#(
    parameter int MAX_ROWS = 1048576
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        sample_valid,
    output logic        sample_ready,
    input  sample_req_t sample,
    output logic        result_valid,
    input  logic        result_ready,
    output result_req_t result
);

    logic [COUNT_W-1:0] row_count_reg;
    logic [COUNT_W-1:0] row_count_next;
    logic               row_count_wr;
    ctrl_cmd_t          cmd;
    dp_status_t         status;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == ADDR_ROW_COUNT) ? 32'(row_count_reg) : '0;

    assign row_count_wr = psel && penable && pwrite && (paddr[2] == ADDR_ROW_COUNT);

    always_comb
    begin
        row_count_next = row_count_reg;
        if (row_count_wr)
        begin
            row_count_next = pwdata[COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= ROW_COUNT_RESET;
        end
        else
        begin
            row_count_reg <= row_count_next;
        end
    end

    svc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .status       (status),
        .cmd          (cmd)
    );

    svc_datapath #(
        .MAX_ROWS (MAX_ROWS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample       (sample),
        .row_count    (row_count_reg),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    `SVC_ASSERT_NEXT(a_one_at_a_time, sample_valid && sample_ready, !sample_ready)
    `SVC_ASSERT_NEXT(a_cfg_write, row_count_wr, row_count_reg == $past(pwdata[COUNT_W-1:0]))
    `SVC_ASSERT_NOW(a_ovf_saturates, result_valid && result.overflow, result.variance == '1)

endmodule

### dv/sparse_column_variance_checker.sv
module sparse_column_variance_checker
    import svc_pkg::*;
#(
    parameter int MAX_ROWS = 1048576
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    input  logic        sample_valid,
    input  logic        sample_ready,
    input  sample_req_t sample,
    input  logic        result_valid,
    input  logic        result_ready,
    input  result_req_t result,
    output int          mismatch_count,
    output int          pending_results
);

    localparam logic [2:0] ROW_COUNT_ADDR = 3'(4 * ADDR_ROW_COUNT);

    logic [COUNT_W-1:0] row_count_q;
    logic [63:0]        square_sum_q;
    logic [COUNT_W-1:0] nonzero_count_q;
    logic               sum_saturated_q;
    result_req_t        variance_expected[$];
    int                 fails = 0;

    task automatic absorb_sample(input sample_req_t req);
        logic [32:0]  dev;
        logic [32:0]  dev_mag;
        logic [63:0]  dev_sq;
        logic [64:0]  sum_next;
        logic [31:0]  mean_raw;
        logic [31:0]  mean_mag;
        logic [63:0]  mean_sq;
        logic [31:0]  rows;
        logic [31:0]  zeros;
        logic [31:0]  divisor;
        logic [127:0] numer;
        logic [127:0] quot;
        result_req_t  res;
        if (req.has_value)
        begin
            dev = {req.sample_value[31], req.sample_value} - {req.col_mean[31], req.col_mean};
            dev_mag = dev[32] ? -dev : dev;
            dev_sq = {31'b0, dev_mag} * {31'b0, dev_mag};
            sum_next = {1'b0, square_sum_q} + {1'b0, dev_sq};
            if (sum_next[64])
            begin
                square_sum_q = '1;
                sum_saturated_q = 1'b1;
            end
            else
                square_sum_q = sum_next[63:0];
            if (nonzero_count_q != COUNT_MAX)
                nonzero_count_q = nonzero_count_q + COUNT_W'(1);
        end
        if (req.end_of_column)
        begin
            rows = (32'(row_count_q) < 32'(MAX_ROWS)) ? 32'(row_count_q) : 32'(MAX_ROWS);
            zeros = (32'(nonzero_count_q) < rows) ? rows - 32'(nonzero_count_q) : 32'd0;
            divisor = (rows >= 32'd2) ? rows - 32'd1 : 32'd1;
            mean_raw = req.col_mean;
            mean_mag = mean_raw[31] ? -mean_raw : mean_raw;
            mean_sq = {32'b0, mean_mag} * {32'b0, mean_mag};
            numer = {64'b0, mean_sq} * {96'b0, zeros} + {64'b0, square_sum_q};
            quot = numer / {96'b0, divisor};
            if (sum_saturated_q || quot[127:64] != '0)
            begin
                res.variance = '1;
                res.overflow = 1'b1;
            end
            else
            begin
                res.variance = quot[63:0];
                res.overflow = 1'b0;
            end
            variance_expected.push_back(res);
            square_sum_q = '0;
            nonzero_count_q = '0;
            sum_saturated_q = 1'b0;
        end
    endtask

    task automatic compare_result(input result_req_t got);
        result_req_t want;
        if (variance_expected.size() == 0)
        begin
            fails++;
            $display("%0t unexpected result: variance %h overflow %b",
                     $time, got.variance, got.overflow);
        end
        else
        begin
            want = variance_expected.pop_front();
            if (got.variance !== want.variance)
            begin
                fails++;
                $display("%0t variance: expected %h, actual %h",
                         $time, want.variance, got.variance);
            end
            if (got.overflow !== want.overflow)
            begin
                fails++;
                $display("%0t overflow: expected %b, actual %b",
                         $time, want.overflow, got.overflow);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_q = ROW_COUNT_RESET;
            square_sum_q = '0;
            nonzero_count_q = '0;
            sum_saturated_q = 1'b0;
            variance_expected.delete();
            pending_results <= 0;
            mismatch_count <= fails;
        end
        else
        begin
            if (psel && penable && !pwrite && pready && paddr == ROW_COUNT_ADDR
                && prdata !== 32'(row_count_q))
            begin
                fails++;
                $display("%0t row_count read: expected %h, actual %h",
                         $time, 32'(row_count_q), prdata);
            end
            if (psel && penable && pwrite && pready && paddr == ROW_COUNT_ADDR)
                row_count_q = pwdata[COUNT_W-1:0];
            if (sample_valid && sample_ready)
                absorb_sample(sample);
            if (result_valid && result_ready)
                compare_result(result);
            pending_results <= variance_expected.size();
            mismatch_count <= fails;
        end
    end

endmodule

### dv/sparse_column_variance_tb.sv
module sparse_column_variance_tb;
    import svc_pkg::*;

    localparam int MAX_ROWS = 1048576;
    localparam int CLK_PERIOD = 20;
    localparam int SETTLE_CYCLES = 120;
    localparam int LONG_HOLD = 600;
    localparam int PHASE_ITEMS = 200;
    localparam int LIMIT_CYCLES = 1000000;
    localparam logic [2:0] ROW_COUNT_ADDR = 3'(4 * ADDR_ROW_COUNT);
    localparam logic [2:0] SPARE_ADDR = 3'(4 * (ADDR_ROW_COUNT + 1));
    localparam logic [31:0] Q_MAX = 32'h7FFFFFFF;
    localparam logic [31:0] Q_MIN = 32'h80000000;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        sample_valid;
    logic        sample_ready;
    sample_req_t sample;
    logic        result_valid;
    logic        result_ready;
    result_req_t result;
    int          mismatch_count;
    int          pending_results;
    int          idle_pct = 0;
    int          stall_pct = 0;
    logic        long_hold_go;

    sparse_column_variance #(.MAX_ROWS(MAX_ROWS)) i_dut (
        .clk,
        .rst_n,
        .psel,
        .penable,
        .pwrite,
        .paddr,
        .pwdata,
        .prdata,
        .pready,
        .sample_valid,
        .sample_ready,
        .sample,
        .result_valid,
        .result_ready,
        .result
    );

    sparse_column_variance_checker #(.MAX_ROWS(MAX_ROWS)) i_checker (
        .clk,
        .rst_n,
        .psel,
        .penable,
        .pwrite,
        .paddr,
        .pwdata,
        .prdata,
        .pready,
        .sample_valid,
        .sample_ready,
        .sample,
        .result_valid,
        .result_ready,
        .result,
        .mismatch_count,
        .pending_results
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("sparse_column_variance_tb failed");
        $finish;
    end

    // result side: random stalls plus one long hold-off on request
    initial
    begin
        int  remaining;
        bit  hold_taken;
        remaining = 0;
        hold_taken = 1'b0;
        result_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_go && !hold_taken)
            begin
                hold_taken = 1'b1;
                remaining = LONG_HOLD;
            end
            if (remaining > 0)
            begin
                remaining--;
                result_ready <= 1'b0;
            end
            else
                result_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic sample_req_t make_req(input logic [31:0] value, input logic [31:0] mean,
                                             input logic has, input logic last);
        sample_req_t req;
        req.sample_value = value;
        req.col_mean = mean;
        req.has_value = has;
        req.end_of_column = last;
        return req;
    endfunction

    function automatic logic [31:0] extreme_q16();
        case ($urandom_range(4))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return 32'h0;
            3: return 32'h1;
            default: return 32'hFFFFFFFF;
        endcase
    endfunction

    function automatic logic [31:0] pick_mean();
        int pick;
        pick = $urandom_range(99);
        if (pick < 30)
            return 32'(int'($urandom_range(524287)) - 262144);
        else if (pick < 50)
            return $urandom;
        else if (pick < 60)
            return extreme_q16();
        else
            return 32'(int'($urandom_range(33554431)) - 16777216);
    endfunction

    function automatic logic [31:0] pick_value(input logic [31:0] mean);
        int pick;
        pick = $urandom_range(99);
        if (pick < 35)
            return mean + 32'(int'($urandom_range(131071)) - 65536);
        else if (pick < 60)
            return 32'(int'($urandom_range(524287)) - 262144);
        else if (pick < 85)
            return $urandom;
        else
            return extreme_q16();
    endfunction

    task automatic send_request(input sample_req_t req);
        if ($urandom_range(99) < idle_pct)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct)
                @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample <= req;
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
    endtask

    task automatic send_column(output int count);
        int          len;
        int          pick;
        logic [31:0] mean;
        bit          ends_with_marker;
        pick = $urandom_range(99);
        if (pick < 10)
            len = 0;
        else if (pick < 70)
            len = $urandom_range(3, 1);
        else if (pick < 95)
            len = $urandom_range(8, 4);
        else
            len = $urandom_range(24, 9);
        mean = pick_mean();
        ends_with_marker = (len > 0) && ($urandom_range(9) == 0);
        count = 0;
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(19) == 0)
                send_request(make_req($urandom, $urandom, 1'b0, 1'b0));
            send_request(make_req(pick_value(mean), mean, 1'b1,
                                  !ends_with_marker && i == len - 1));
            count++;
        end
        if (len == 0 || ends_with_marker)
        begin
            send_request(make_req($urandom, mean, 1'b0, 1'b1));
            count++;
        end
    endtask

    task automatic drain();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_rows(input logic [COUNT_W-1:0] rows, input bit dirty_upper);
        logic [31:0] data;
        data = 32'(rows);
        if (dirty_upper)
            data[31:COUNT_W] = (32 - COUNT_W)'($urandom);
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        apb_access(1'b1, ROW_COUNT_ADDR, data);
        apb_access(1'b0, ROW_COUNT_ADDR, '0);
    endtask

    initial
    begin
        int                 sent;
        int                 n;
        bit                 paused;
        logic [COUNT_W-1:0] rows;
        paused = 1'b0;
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        sample_valid <= 1'b0;
        sample <= '0;
        long_hold_go <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        apb_access(1'b0, ROW_COUNT_ADDR, '0);

        // largest deviation: quotient overflows with two rows
        send_request(make_req(Q_MAX, Q_MIN, 1'b1, 1'b1));
        // sum of squares saturates
        send_request(make_req(Q_MIN, Q_MAX, 1'b1, 1'b0));
        send_request(make_req(Q_MAX, Q_MIN, 1'b1, 1'b1));
        // empty columns
        send_request(make_req($urandom, Q_MIN, 1'b0, 1'b1));
        send_request(make_req(32'h0, 32'h0, 1'b0, 1'b1));
        send_request(make_req(Q_MAX, Q_MAX, 1'b0, 1'b1));
        // marker without end is ignored
        send_request(make_req(32'h12345678, 32'hFFFF0000, 1'b0, 1'b0));
        send_request(make_req(32'h00010000, 32'h00008000, 1'b1, 1'b1));
        // more nonzeros than rows
        send_request(make_req(32'h0, 32'h00020000, 1'b1, 1'b0));
        send_request(make_req(32'h00010000, 32'h00020000, 1'b1, 1'b0));
        send_request(make_req(32'hFFFF0000, 32'h00020000, 1'b1, 1'b0));
        send_request(make_req(Q_MAX, 32'h00020000, 1'b1, 1'b1));
        send_request(make_req(Q_MIN, Q_MIN, 1'b1, 1'b1));
        // column closed by a marker
        send_request(make_req(32'h00030000, 32'h00010000, 1'b1, 1'b0));
        send_request(make_req($urandom, 32'h00010000, 1'b0, 1'b1));

        set_rows('0, 1'b0);
        send_request(make_req(32'h00050000, 32'h0, 1'b1, 1'b1));
        set_rows(COUNT_W'(1), 1'b1);
        send_request(make_req(32'hFFFFFFFF, Q_MAX, 1'b1, 1'b1));
        set_rows(COUNT_MAX, 1'b1);
        apb_access(1'b1, SPARE_ADDR, $urandom);
        apb_access(1'b0, ROW_COUNT_ADDR, '0);
        send_request(make_req($urandom, Q_MIN, 1'b0, 1'b1));
        send_request(make_req(Q_MAX, Q_MIN, 1'b1, 1'b1));
        set_rows(COUNT_W'(MAX_ROWS), 1'b0);
        send_request(make_req(32'h00020000, 32'hFFFF8000, 1'b1, 1'b0));
        send_request(make_req(Q_MIN, 32'hFFFF8000, 1'b1, 1'b1));

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: rows = COUNT_W'(2);
                1: rows = COUNT_W'($urandom_range(16, 3));
                2: rows = COUNT_W'($urandom_range(1, 0));
                3: rows = COUNT_W'($urandom_range(5000, 17));
                4: rows = COUNT_MAX;
                5: rows = COUNT_W'(MAX_ROWS);
                6: rows = COUNT_W'($urandom_range(64, 2));
                default: rows = COUNT_W'($urandom_range(32'(COUNT_MAX), 2));
            endcase
            set_rows(rows, ph[0]);
            case (ph % 4)
                0:
                begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct = 64;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct = 64;
                end
                default:
                begin
                    idle_pct = 7;
                    stall_pct = 7;
                end
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                if (ph == 2 && sent >= 40)
                    long_hold_go <= 1'b1;
                if (ph == 1 && sent >= 100 && !paused)
                begin
                    paused = 1'b1;
                    drain();
                end
                send_column(n);
                sent += n;
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_results == 0)
            $display("sparse_column_variance_tb passed");
        else
            $display("sparse_column_variance_tb failed");
        $finish;
    end

endmodule
